[hw/rtl/gpm_pkg.sv]
package gpm_pkg;

    localparam int DEF_MAX_SEGMENTS      = 16;
    localparam int DEF_MAX_LITERAL_BYTES = 64;
    localparam int DEF_MAX_CANDIDATE     = 256;

    localparam logic [1:0] OP_PATTERN = 2'd0;
    localparam logic [1:0] OP_CAND    = 2'd1;
    localparam logic [1:0] OP_RUN     = 2'd2;

    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_STAR    = 2'd1;
    localparam logic [1:0] KIND_SINGLE  = 2'd2;
    localparam logic [1:0] KIND_LITERAL = 2'd3;

    localparam logic [7:0] DOT_BYTE = 8'h2E;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BEGIN,
        ST_PREFIX,
        ST_PREFIX_CHK,
        ST_LIT,
        ST_LIT_CHK,
        ST_BACK,
        ST_CHECK,
        ST_OUT
    } gpm_state_t;

    typedef struct packed {
        logic run_init;
        logic seg_begin;
        logic pfx_adv;
        logic lit_adv;
        logic seg_next;
        logic back;
        logic finish;
        logic match_val;
        logic out_load;
    } gpm_cmd_t;

    typedef struct packed {
        logic seg_end;
        logic pfx_single;
        logic pfx_ok;
        logic lit_done;
        logic lit_ok;
        logic back_ok;
        logic full;
        logic out_free;
        logic out_last;
    } gpm_stat_t;

endpackage

[hw/rtl/gpm_ram.sv]
module gpm_ram
    import gpm_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
)
(
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                       wdata,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/gpm_ctrl.sv]
module gpm_ctrl
    import gpm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic [1:0] opcode,
    input  gpm_stat_t stat,
    output logic      in_stall,
    output gpm_cmd_t  cmd
);

    gpm_state_t state_reg;
    gpm_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid && opcode == OP_RUN)
                begin
                    cmd.run_init = 1'b1;
                    state_next   = ST_BEGIN;
                end
            end
            ST_BEGIN:
            begin
                if (stat.seg_end)
                begin
                    state_next = ST_CHECK;
                end
                else
                begin
                    cmd.seg_begin = 1'b1;
                    state_next    = ST_PREFIX;
                end
            end
            ST_PREFIX:
            begin
                // candidate byte read is issued here for the single wildcard
                state_next = stat.pfx_single ? ST_PREFIX_CHK : ST_LIT;
            end
            ST_PREFIX_CHK:
            begin
                if (stat.pfx_ok)
                begin
                    cmd.pfx_adv = 1'b1;
                    state_next  = ST_LIT;
                end
                else
                begin
                    state_next = ST_BACK;
                end
            end
            ST_LIT:
            begin
                if (stat.lit_done)
                begin
                    cmd.seg_next = 1'b1;
                    state_next   = ST_BEGIN;
                end
                else
                begin
                    state_next = ST_LIT_CHK;
                end
            end
            ST_LIT_CHK:
            begin
                if (stat.lit_ok)
                begin
                    cmd.lit_adv = 1'b1;
                    state_next  = ST_LIT;
                end
                else
                begin
                    state_next = ST_BACK;
                end
            end
            ST_BACK:
            begin
                if (stat.back_ok)
                begin
                    cmd.back   = 1'b1;
                    state_next = ST_PREFIX;
                end
                else
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_CHECK:
            begin
                if (stat.full)
                begin
                    cmd.finish    = 1'b1;
                    cmd.match_val = 1'b1;
                    state_next    = ST_OUT;
                end
                else
                begin
                    state_next = ST_BACK;
                end
            end
            ST_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (stat.out_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_back_only_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.back |-> ($past(state_reg) == ST_PREFIX_CHK || $past(state_reg) == ST_LIT_CHK
                      || $past(state_reg) == ST_CHECK))
        else $error("backtrack entered without a failed step");
    a_finish_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> state_reg == ST_OUT)
        else $error("finished run did not move to result delivery");
    a_run_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.run_init |-> !in_stall)
        else $error("run started while input stalled");

endmodule

[hw/rtl/gpm_dp.sv]
module gpm_dp
    import gpm_pkg::*;
#(
    parameter int MAX_SEGMENTS      = DEF_MAX_SEGMENTS,
    parameter int MAX_LITERAL_BYTES = DEF_MAX_LITERAL_BYTES,
    parameter int MAX_CANDIDATE     = DEF_MAX_CANDIDATE
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_accept,
    input  logic [1:0] opcode,
    input  logic [1:0] token_kind,
    input  logic       restart,
    input  logic [7:0] byte_req,
    input  gpm_cmd_t   cmd,
    output gpm_stat_t  stat,
    input  logic       out_stall,
    output logic       out_valid,
    output logic       matched,
    output logic [3:0] segment_index,
    output logic [8:0] start_index,
    output logic       has_index,
    output logic       overflow,
    output logic       last
);

    localparam int SW   = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CNTW = $clog2(MAX_SEGMENTS + 1);
    localparam int LAW  = (MAX_LITERAL_BYTES > 1) ? $clog2(MAX_LITERAL_BYTES) : 1;
    localparam int LCW  = $clog2(MAX_LITERAL_BYTES + 1);
    localparam int CAW  = (MAX_CANDIDATE > 1) ? $clog2(MAX_CANDIDATE) : 1;
    localparam int CW   = $clog2(MAX_CANDIDATE + 1);
    localparam int SUMW = ((CW > LCW) ? CW : LCW) + 2;

    // pattern tables
    logic [1:0]     pfx_reg   [MAX_SEGMENTS];
    logic [LCW-1:0] off_reg   [MAX_SEGMENTS];
    logic [LCW-1:0] len_reg   [MAX_SEGMENTS];
    logic [CW-1:0]  start_reg [MAX_SEGMENTS];

    logic [CNTW-1:0] count_reg;
    logic [LCW-1:0]  used_reg;
    logic            drop_reg;
    logic [CW-1:0]   cand_len_reg;
    logic            ovf_reg;

    // matcher registers
    logic [CNTW-1:0] cur_seg_reg;
    logic [CW-1:0]   cur_pos_reg;
    logic [CW-1:0]   mark_pos_reg;
    logic [SW-1:0]   mark_seg_reg;
    logic            mark_valid_reg;
    logic [LCW-1:0]  k_reg;
    logic            match_reg;
    logic [SW-1:0]   oidx_reg;

    logic            out_valid_reg;
    logic            matched_reg;
    logic [3:0]      segment_index_reg;
    logic [8:0]      start_index_reg;
    logic            has_index_reg;
    logic            overflow_reg;
    logic            last_reg;

    logic            pat;
    logic            cnd;
    logic [CNTW-1:0] cnt_eff;
    logic [CNTW-1:0] seg_last;
    logic [LCW-1:0]  used_eff;
    logic            drop_eff;
    logic            lit_take;
    logic            lit_ovf;
    logic            seg_take;
    logic            seg_ovf;
    logic            cand_take;
    logic            cand_ovf;

    logic [SW-1:0]   cur_idx;
    logic [LCW:0]    lit_addr;
    logic [CW:0]     mark_inc;
    logic [SUMW-1:0] back_sum;
    logic [LAW-1:0]  lit_ram_addr;
    logic [CAW-1:0]  cand_ram_addr;
    logic [7:0]      lit_rdata;
    logic [7:0]      cand_rdata;
    logic            pos_in;

    always_comb
    begin
        pat       = in_accept && opcode == OP_PATTERN;
        cnd       = in_accept && opcode == OP_CAND;
        cnt_eff   = restart ? '0 : count_reg;
        used_eff  = restart ? '0 : used_reg;
        drop_eff  = restart ? 1'b0 : drop_reg;
        seg_last  = cnt_eff - CNTW'(1);
        lit_take  = pat && token_kind == KIND_LITERAL && cnt_eff != '0 && !drop_eff
                    && {1'b0, used_eff} < (LCW+1)'(MAX_LITERAL_BYTES);
        lit_ovf   = pat && token_kind == KIND_LITERAL && cnt_eff != '0 && !drop_eff
                    && {1'b0, used_eff} >= (LCW+1)'(MAX_LITERAL_BYTES);
        seg_take  = pat && token_kind != KIND_LITERAL
                    && {1'b0, cnt_eff} < (CNTW+1)'(MAX_SEGMENTS);
        seg_ovf   = pat && token_kind != KIND_LITERAL
                    && {1'b0, cnt_eff} >= (CNTW+1)'(MAX_SEGMENTS);
        cand_take = cnd && {1'b0, cand_len_reg} < (CW+1)'(MAX_CANDIDATE);
        cand_ovf  = cnd && !cand_take;
    end

    assign cur_idx  = cur_seg_reg[SW-1:0];
    assign lit_addr = {1'b0, off_reg[cur_idx]} + {1'b0, k_reg};
    assign mark_inc = {1'b0, mark_pos_reg} + (CW+1)'(1);
    assign back_sum = SUMW'(mark_inc) + SUMW'(len_reg[mark_seg_reg]);
    assign pos_in   = cur_pos_reg < cand_len_reg;

    assign lit_ram_addr  = lit_take ? used_eff[LAW-1:0] : lit_addr[LAW-1:0];
    assign cand_ram_addr = cand_take ? cand_len_reg[CAW-1:0] : cur_pos_reg[CAW-1:0];

    gpm_ram #(
        .WIDTH (8),
        .DEPTH (MAX_LITERAL_BYTES)
    ) u_lit_ram (
        .clk   (clk),
        .we    (lit_take),
        .addr  (lit_ram_addr),
        .wdata (byte_req),
        .rdata (lit_rdata)
    );

    gpm_ram #(
        .WIDTH (8),
        .DEPTH (MAX_CANDIDATE)
    ) u_cand_ram (
        .clk   (clk),
        .we    (cand_take),
        .addr  (cand_ram_addr),
        .wdata (byte_req),
        .rdata (cand_rdata)
    );

    always_comb
    begin
        stat.seg_end    = {1'b0, cur_seg_reg} >= {1'b0, count_reg};
        stat.pfx_single = pfx_reg[cur_idx] == KIND_SINGLE;
        stat.pfx_ok     = pos_in && cand_rdata != DOT_BYTE;
        stat.lit_done   = k_reg == len_reg[cur_idx];
        stat.lit_ok     = pos_in && lit_addr < (LCW+1)'(MAX_LITERAL_BYTES)
                          && cand_rdata == lit_rdata;
        stat.back_ok    = mark_valid_reg && back_sum <= SUMW'(cand_len_reg);
        stat.full       = cur_pos_reg == cand_len_reg;
        stat.out_free   = !out_valid_reg || !out_stall;
        stat.out_last   = count_reg == '0 || CNTW'(oidx_reg) == count_reg - CNTW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            used_reg       <= '0;
            drop_reg       <= 1'b0;
            cand_len_reg   <= '0;
            ovf_reg        <= 1'b0;
            cur_seg_reg    <= '0;
            cur_pos_reg    <= '0;
            mark_pos_reg   <= '0;
            mark_seg_reg   <= '0;
            mark_valid_reg <= 1'b0;
            k_reg          <= '0;
            match_reg      <= 1'b0;
            oidx_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (pat)
            begin
                count_reg <= cnt_eff + CNTW'(seg_take);
                used_reg  <= used_eff + LCW'(lit_take);
                drop_reg  <= seg_ovf || (drop_eff && !seg_take);
            end
            if (cand_take)
            begin
                cand_len_reg <= cand_len_reg + CW'(1);
            end
            if (lit_ovf || seg_ovf || cand_ovf)
            begin
                ovf_reg <= 1'b1;
            end

            if (cmd.run_init)
            begin
                cur_seg_reg    <= '0;
                cur_pos_reg    <= '0;
                mark_valid_reg <= 1'b0;
                k_reg          <= '0;
                oidx_reg       <= '0;
            end
            if (cmd.seg_begin)
            begin
                k_reg <= '0;
                if (pfx_reg[cur_idx] == KIND_STAR)
                begin
                    mark_pos_reg   <= cur_pos_reg;
                    mark_seg_reg   <= cur_idx;
                    mark_valid_reg <= 1'b1;
                end
            end
            if (cmd.pfx_adv)
            begin
                cur_pos_reg <= cur_pos_reg + CW'(1);
            end
            if (cmd.lit_adv)
            begin
                cur_pos_reg <= cur_pos_reg + CW'(1);
                k_reg       <= k_reg + LCW'(1);
            end
            if (cmd.seg_next)
            begin
                cur_seg_reg <= cur_seg_reg + CNTW'(1);
            end
            if (cmd.back)
            begin
                // star swallows one more character
                mark_pos_reg <= mark_inc[CW-1:0];
                cur_pos_reg  <= mark_inc[CW-1:0];
                cur_seg_reg  <= CNTW'(mark_seg_reg);
                k_reg        <= '0;
            end
            if (cmd.finish)
            begin
                match_reg <= cmd.match_val;
            end

            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
                if (stat.out_last)
                begin
                    oidx_reg     <= '0;
                    cand_len_reg <= '0;
                    ovf_reg      <= 1'b0;
                end
                else
                begin
                    oidx_reg <= oidx_reg + SW'(1);
                end
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (seg_take)
        begin
            pfx_reg[cnt_eff[SW-1:0]] <= token_kind;
            off_reg[cnt_eff[SW-1:0]] <= used_eff;
            len_reg[cnt_eff[SW-1:0]] <= '0;
        end
        if (lit_take)
        begin
            len_reg[seg_last[SW-1:0]] <= len_reg[seg_last[SW-1:0]] + LCW'(1);
        end
        if (cmd.run_init)
        begin
            for (int i = 0; i < MAX_SEGMENTS; i++)
            begin
                start_reg[i] <= '0;
            end
        end
        else if (cmd.seg_begin)
        begin
            start_reg[cur_idx] <= cur_pos_reg;
        end
        if (cmd.out_load)
        begin
            matched_reg       <= match_reg;
            segment_index_reg <= 4'(oidx_reg);
            start_index_reg   <= (count_reg == '0) ? 9'd0 : 9'(start_reg[oidx_reg]);
            has_index_reg     <= count_reg != '0;
            overflow_reg      <= ovf_reg;
            last_reg          <= stat.out_last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign matched       = matched_reg;
    assign segment_index = segment_index_reg;
    assign start_index   = start_index_reg;
    assign has_index     = has_index_reg;
    assign overflow      = overflow_reg;
    assign last          = last_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, count_reg} <= (CNTW+1)'(MAX_SEGMENTS))
        else $error("segment count beyond table");
    a_cand_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, cand_len_reg} <= (CW+1)'(MAX_CANDIDATE))
        else $error("candidate length beyond store");
    a_lit_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, used_reg} <= (LCW+1)'(MAX_LITERAL_BYTES))
        else $error("literal fill beyond store");
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || !out_stall))
        else $error("result overwritten before transfer");

endmodule

[hw/rtl/glob_pattern_matcher.sv]
// channel | handshake           | payload
// in      | in_valid / in_stall | opcode token_kind restart byte_req
// out     | out_valid/out_stall | matched segment_index start_index has_index overflow last
//
// pattern and candidate items each load while in_stall is low
// a run steps through each segment attempt, with an extra check for a single wildcard, then
// each compared byte, each backtrack and the close of the run, paced by the single read port of
// the candidate and literal memories, then delivers one result per cycle when out_stall is low
// input is stalled from the run item until the last result is loaded into the output register
// rst_n clears counts and flags; pattern and candidate memories hold no reset value
module glob_pattern_matcher
    import gpm_pkg::*;
#(
    parameter int MAX_SEGMENTS      = DEF_MAX_SEGMENTS,
    parameter int MAX_LITERAL_BYTES = DEF_MAX_LITERAL_BYTES,
    parameter int MAX_CANDIDATE     = DEF_MAX_CANDIDATE
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] opcode,
    input  logic [1:0] token_kind,
    input  logic       restart,
    input  logic [7:0] byte_req,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       matched,
    output logic [3:0] segment_index,
    output logic [8:0] start_index,
    output logic       has_index,
    output logic       overflow,
    output logic       last
);

    gpm_cmd_t  cmd;
    gpm_stat_t stat;
    logic      in_accept;

    assign in_accept = in_valid && !in_stall;

    gpm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .opcode   (opcode),
        .stat     (stat),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    gpm_dp #(
        .MAX_SEGMENTS      (MAX_SEGMENTS),
        .MAX_LITERAL_BYTES (MAX_LITERAL_BYTES),
        .MAX_CANDIDATE     (MAX_CANDIDATE)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_accept     (in_accept),
        .opcode        (opcode),
        .token_kind    (token_kind),
        .restart       (restart),
        .byte_req      (byte_req),
        .cmd           (cmd),
        .stat          (stat),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .matched       (matched),
        .segment_index (segment_index),
        .start_index   (start_index),
        .has_index     (has_index),
        .overflow      (overflow),
        .last          (last)
    );

endmodule
